[hw/rtl/rcl_pkg.sv]
// Shared types, codes and character helpers for the RGB command-line parser.
package rcl_pkg;

	localparam int LINE_LIMIT = 63;
	localparam int CNT_W      = $clog2(LINE_LIMIT);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [8:0] ACC_SAT  = 9'd256;
	localparam logic [8:0] ACC_MAX  = 9'd255;

	typedef enum logic [2:0] {
		ST_WRITE   = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_MISSING = 3'd3,
		ST_BAD     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CHAN_RED   = 2'd0,
		CHAN_GREEN = 2'd1,
		CHAN_BLUE  = 2'd2
	} chan_t;

	typedef enum logic {
		KIND_ECHO = 1'b0,
		KIND_CMD  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		AS_LEAD   = 2'd0,
		AS_SIGN   = 2'd1,
		AS_DIGITS = 2'd2,
		AS_ERROR  = 2'd3
	} arg_stage_t;

	// One classified byte: its echo and, when it ends a line, the command result.
	typedef struct packed {
		logic [7:0] echo;
		logic       done;
		status_t    status;
		chan_t      channel;
		logic [7:0] brightness;
	} rcl_item_t;

	function automatic logic red_hit(input logic [2:0] pos, input logic [7:0] c);
		logic hit;
		unique case (pos)
			3'd0:    hit = (c == 8'h72);
			3'd1:    hit = (c == 8'h65);
			3'd2:    hit = (c == 8'h64);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic green_hit(input logic [2:0] pos, input logic [7:0] c);
		logic hit;
		unique case (pos)
			3'd0:    hit = (c == 8'h67);
			3'd1:    hit = (c == 8'h72);
			3'd2:    hit = (c == 8'h65);
			3'd3:    hit = (c == 8'h65);
			3'd4:    hit = (c == 8'h6E);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic blue_hit(input logic [2:0] pos, input logic [7:0] c);
		logic hit;
		unique case (pos)
			3'd0:    hit = (c == 8'h62);
			3'd1:    hit = (c == 8'h6C);
			3'd2:    hit = (c == 8'h75);
			3'd3:    hit = (c == 8'h65);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

[hw/rtl/rcl_front.sv]
// Front end: accepts bytes, tracks the line parse and classifies each byte.
module rcl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output logic              q_push,
	output rcl_pkg::rcl_item_t q_item
);
	import rcl_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [2:0]       name_pos_q, n_name_pos;
	logic             in_arg_q, n_in_arg;
	logic [2:0]       match_q, n_match;
	logic             arg_seen_q, n_arg_seen;
	arg_stage_t       stage_q, n_stage;
	logic             neg_q, n_neg;
	logic [8:0]       acc_q, n_acc;

	logic             is_cr, is_space, is_digit, end_line;
	logic [11:0]      prod;
	status_t          status;
	chan_t            chan;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	assign is_cr    = (rx_byte == CH_CR);
	assign is_space = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign end_line = is_cr || (count_q == CNT_W'(LINE_LIMIT - 1));
	assign prod     = 12'({3'b000, acc_q} * 12'd10) + {8'h00, rx_byte[3:0]};

	// Parse state after this byte; a carriage return leaves it untouched.
	always_comb begin
		n_name_pos = name_pos_q;
		n_in_arg   = in_arg_q;
		n_match    = match_q;
		n_arg_seen = arg_seen_q;
		n_stage    = stage_q;
		n_neg      = neg_q;
		n_acc      = acc_q;
		if (!is_cr) begin
			if (in_arg_q) begin
				n_arg_seen = 1'b1;
				unique case (stage_q)
					AS_LEAD: begin
						if (is_space) begin
							n_stage = AS_LEAD;
						end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
							n_neg   = (rx_byte == CH_MINUS);
							n_stage = AS_SIGN;
						end else if (is_digit) begin
							n_stage = AS_DIGITS;
							n_acc   = {5'd0, rx_byte[3:0]};
						end else begin
							n_stage = AS_ERROR;
						end
					end
					AS_SIGN, AS_DIGITS: begin
						if (!is_digit) begin
							n_stage = AS_ERROR;
						end else begin
							n_stage = AS_DIGITS;
							n_acc   = (prod > 12'(ACC_SAT)) ? ACC_SAT : prod[8:0];
						end
					end
					default: n_stage = AS_ERROR;
				endcase
			end else if (rx_byte == CH_SPACE) begin
				n_in_arg = 1'b1;
			end else begin
				n_match[0] = match_q[0] && red_hit(name_pos_q, rx_byte);
				n_match[1] = match_q[1] && green_hit(name_pos_q, rx_byte);
				n_match[2] = match_q[2] && blue_hit(name_pos_q, rx_byte);
				if (name_pos_q != 3'd7) begin
					n_name_pos = name_pos_q + 3'd1;
				end
			end
		end
	end

	// Command result from the parse state after this byte.
	always_comb begin
		chan = CHAN_RED;
		priority if (n_name_pos == 3'd0) begin
			status = ST_EMPTY;
		end else if (n_match == 3'b000) begin
			status = ST_UNKNOWN;
		end else if (!n_in_arg || !n_arg_seen) begin
			status = ST_MISSING;
		end else if (n_stage != AS_DIGITS ||
				(n_neg ? (n_acc != 9'd0) : (n_acc > ACC_MAX))) begin
			status = ST_BAD;
		end else begin
			status = ST_WRITE;
			priority if (n_match[0]) begin
				chan = CHAN_RED;
			end else if (n_match[1]) begin
				chan = CHAN_GREEN;
			end else begin
				chan = CHAN_BLUE;
			end
		end
	end

	always_comb begin
		q_item.echo       = is_cr ? CH_LF : rx_byte;
		q_item.done       = end_line;
		q_item.status     = status;
		q_item.channel    = chan;
		q_item.brightness = (status == ST_WRITE) ? n_acc[7:0] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			name_pos_q <= 3'd0;
			in_arg_q   <= 1'b0;
			match_q    <= 3'b111;
			arg_seen_q <= 1'b0;
			stage_q    <= AS_LEAD;
			neg_q      <= 1'b0;
			acc_q      <= 9'd0;
		end else if (q_push) begin
			if (end_line) begin
				count_q    <= '0;
				name_pos_q <= 3'd0;
				in_arg_q   <= 1'b0;
				match_q    <= 3'b111;
				arg_seen_q <= 1'b0;
				stage_q    <= AS_LEAD;
				neg_q      <= 1'b0;
				acc_q      <= 9'd0;
			end else begin
				count_q    <= count_q + CNT_W'(1);
				name_pos_q <= n_name_pos;
				in_arg_q   <= n_in_arg;
				match_q    <= n_match;
				arg_seen_q <= n_arg_seen;
				stage_q    <= n_stage;
				neg_q      <= n_neg;
				acc_q      <= n_acc;
			end
		end
	end

endmodule

[hw/rtl/rcl_fifo.sv]
// Short queue of classified bytes between the front and back ends.
module rcl_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rcl_pkg::rcl_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output rcl_pkg::rcl_item_t head
);
	import rcl_pkg::*;

	rcl_item_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;

	assign full      = (fill_q == FILL_W'(FIFO_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue read while empty");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(FIFO_DEPTH)) else $error("queue fill out of range");
`endif

endmodule

[hw/rtl/rcl_back.sv]
// Back end: turns each queued byte into its echo beat and any command result beat.
module rcl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rcl_pkg::rcl_item_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [7:0]         echo_byte,
	output logic [2:0]         status,
	output logic [1:0]         channel,
	output logic [7:0]         brightness,
	output logic               last
);
	import rcl_pkg::*;

	rcl_item_t cur_q;
	logic      busy_q;
	kind_t     phase_q;
	logic      advance;

	assign out_valid  = busy_q;
	assign kind       = phase_q;
	assign echo_byte  = (phase_q == KIND_CMD) ? 8'h00 : cur_q.echo;
	assign status     = (phase_q == KIND_CMD) ? cur_q.status : ST_WRITE;
	assign channel    = (phase_q == KIND_CMD) ? cur_q.channel : CHAN_RED;
	assign brightness = (phase_q == KIND_CMD) ? cur_q.brightness : 8'h00;
	assign last       = (phase_q == KIND_CMD) || !cur_q.done;

	// Take the next byte once the current one has sent its final beat.
	assign advance = !busy_q || (out_ready && last);
	assign pop     = advance && head_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= KIND_ECHO;
		end else if (advance) begin
			busy_q  <= head_valid;
			phase_q <= KIND_ECHO;
		end else if (out_ready) begin
			phase_q <= KIND_CMD;
		end
	end

`ifndef SYNTHESIS
	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ECHO) |-> (status == ST_WRITE) && (brightness == 8'h00))
		else $error("echo beat carries command fields");
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CMD) |-> last)
		else $error("command beat not marked last");
	a_cmd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && (kind == KIND_CMD))
		else $error("command beat did not follow its echo");
`endif

endmodule

[hw/rtl/rgb_command_line_parser.sv]
// Top level of the RGB command-line parser: front end, queue and back end.
// An accepted byte passes through the queue into the back end's output register, which
// shows its echo beat; a carriage return or the byte that fills the line adds a command
// beat after the echo. Throughput: one byte per cycle while out_ready is high, limited
// by the single output register; a line-ending byte sends an echo and a command beat.
// Reset clears the line parse state and empties the four-entry queue at once.
module rgb_command_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] echo_byte,
	output logic [2:0] status,
	output logic [1:0] channel,
	output logic [7:0] brightness,
	output logic       last
);
	import rcl_pkg::*;

	rcl_item_t push_item, head;
	logic      push, full, pop, not_empty;

	rcl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	rcl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	rcl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.echo_byte  (echo_byte),
		.status     (status),
		.channel    (channel),
		.brightness (brightness),
		.last       (last)
	);

endmodule

[tb/tb.sv]
// Self-checking testbench for the RGB command-line parser: echo and command beats.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcl_pkg::*;

	localparam int         CYCLE_LIMIT = 60000;
	localparam int         DRAIN_WAIT  = 10;
	localparam logic [7:0] CH_VT       = 8'h0B;
	localparam logic [7:0] CH_FF       = 8'h0C;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] echo;
		status_t    status;
		chan_t      channel;
		logic [7:0] brightness;
		logic       last;
	} reply_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       kind;
	logic [7:0] echo_byte;
	logic [2:0] status;
	logic [1:0] channel;
	logic [7:0] brightness;
	logic       last;

	rgb_command_line_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.echo_byte  (echo_byte),
		.status     (status),
		.channel    (channel),
		.brightness (brightness),
		.last       (last)
	);

	// Line parse state of the predictor
	int         line_len;
	logic [2:0] name_pos;
	logic       in_arg;
	logic [2:0] name_match;
	logic       arg_seen;
	arg_stage_t arg_stage;
	logic       arg_neg;
	logic [8:0] arg_value;

	reply_t reply_q[$];
	int     bytes_sent;
	int     beats_checked;
	int     lines_done;
	int     writes_done;
	int     err_count;
	int     cycles;
	logic   steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_line();
		line_len   = 0;
		name_pos   = '0;
		in_arg     = 1'b0;
		name_match = 3'b111;
		arg_seen   = 1'b0;
		arg_stage  = AS_LEAD;
		arg_neg    = 1'b0;
		arg_value  = '0;
	endfunction

	function automatic logic word_hit(input string w, input int pos, input logic [7:0] c);
		return pos < w.len() && w[pos] == c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void finish_line();
		status_t    st;
		chan_t      ch;
		logic [7:0] br;
		reply_t     r;
		ch = CHAN_RED;
		br = '0;
		if (name_pos == 0) begin
			st = ST_EMPTY;
		end else if (name_match == 3'b000) begin
			st = ST_UNKNOWN;
		end else if (!in_arg || !arg_seen) begin
			st = ST_MISSING;
		end else if (arg_stage != AS_DIGITS ||
				(arg_neg ? arg_value != 0 : arg_value > ACC_MAX)) begin
			st = ST_BAD;
		end else begin
			st = ST_WRITE;
			ch = name_match[0] ? CHAN_RED : (name_match[1] ? CHAN_GREEN : CHAN_BLUE);
			br = arg_value[7:0];
			writes_done++;
		end
		r = {KIND_CMD, 8'h00, st, ch, br, 1'b1};
		reply_q.push_back(r);
		lines_done++;
		clear_line();
	endfunction

	function automatic void parse_arg_byte(input logic [7:0] c);
		logic digit;
		int   v;
		digit    = c >= CH_ZERO && c <= CH_NINE;
		arg_seen = 1'b1;
		case (arg_stage)
			AS_LEAD: begin
				if (is_blank(c)) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					arg_neg   = (c == CH_MINUS);
					arg_stage = AS_SIGN;
				end else if (digit) begin
					arg_stage = AS_DIGITS;
					arg_value = {1'b0, c - CH_ZERO};
				end else begin
					arg_stage = AS_ERROR;
				end
			end
			AS_SIGN, AS_DIGITS: begin
				if (!digit) begin
					arg_stage = AS_ERROR;
				end else begin
					arg_stage = AS_DIGITS;
					v = int'(arg_value) * 10 + int'(c - CH_ZERO);
					arg_value = (v > 256) ? ACC_SAT : 9'(v);
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Work out the beats one accepted byte causes and queue them
	function automatic void parse_rx_byte(input logic [7:0] c);
		reply_t r;
		if (c == CH_CR) begin
			r = {KIND_ECHO, CH_LF, ST_WRITE, CHAN_RED, 8'h00, 1'b0};
			reply_q.push_back(r);
			finish_line();
			return;
		end
		if (in_arg) begin
			parse_arg_byte(c);
		end else if (c == CH_SPACE) begin
			in_arg = 1'b1;
		end else begin
			if (!word_hit("red", name_pos, c))   name_match[0] = 1'b0;
			if (!word_hit("green", name_pos, c)) name_match[1] = 1'b0;
			if (!word_hit("blue", name_pos, c))  name_match[2] = 1'b0;
			if (name_pos < 3'd7) name_pos++;
		end
		line_len++;
		r = {KIND_ECHO, c, ST_WRITE, CHAN_RED, 8'h00, 1'b0};
		if (line_len >= LINE_LIMIT) begin
			reply_q.push_back(r);
			finish_line();
		end else begin
			r.last = 1'b1;
			reply_q.push_back(r);
		end
	endfunction

	task automatic send_byte(input logic [7:0] c);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		do @(posedge clk); while (!in_ready);
		parse_rx_byte(c);
		bytes_sent++;
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
		send_byte(CH_CR);
	endtask

	task automatic send_blank();
		case ($urandom_range(0, 4))
			0:       send_byte(CH_SPACE);
			1:       send_byte(CH_TAB);
			2:       send_byte(CH_LF);
			3:       send_byte(CH_VT);
			default: send_byte(CH_FF);
		endcase
	endtask

	// Mostly well-formed commands with random content, some noise and broken lines
	task automatic send_random_line();
		string      w;
		string      digits;
		int         roll;
		int         n;
		logic [7:0] c;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			n = $urandom_range(0, 70);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
			send_byte(CH_CR);
			return;
		end
		case ($urandom_range(0, 2))
			0:       w = "red";
			1:       w = "green";
			default: w = "blue";
		endcase
		n = $urandom_range(1, w.len());
		for (int k = 0; k < n; k++) begin
			c = w[k];
			if ($urandom_range(0, 99) < 4) c = 8'($urandom_range(0, 255));
			send_byte(c);
		end
		if ($urandom_range(0, 99) < 5) send_byte(8'($urandom_range(8'h61, 8'h7A)));
		if ($urandom_range(0, 99) < 5) begin
			send_byte(CH_CR);
			return;
		end
		send_byte(CH_SPACE);
		if ($urandom_range(0, 99) < 5) begin
			send_byte(CH_CR);
			return;
		end
		repeat ($urandom_range(0, 2)) send_blank();
		roll = $urandom_range(0, 99);
		if (roll < 15) send_byte(CH_PLUS);
		else if (roll < 30) send_byte(CH_MINUS);
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			send_byte(CH_ZERO);
		end else if (roll < 92) begin
			digits = $sformatf("%0d", (roll < 75) ? $urandom_range(0, 255) :
				$urandom_range(256, 999));
			for (int k = 0; k < digits.len(); k++) send_byte(digits[k]);
		end else begin
			repeat ($urandom_range(4, 12)) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 99) < 6) send_byte(8'($urandom_range(0, 255)));
		send_byte(CH_CR);
	endtask

	task automatic test_empty_and_missing();
		send_line("");
		send_line(" 5");
		send_line("b");
		send_line("gre ");
	endtask

	task automatic test_names();
		send_line("greens 1");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_line("r 9");
	endtask

	task automatic test_values();
		send_line("green 255");
		send_line("bl -0");
		send_byte("b");
		send_byte(CH_SPACE);
		send_byte(CH_TAB);
		send_byte(CH_VT);
		send_byte(CH_FF);
		send_byte(CH_LF);
		send_line("+42");
		send_line("red 256");
		send_line("r 4x");
		send_line("r -1");
	endtask

	// Fill the line without a carriage return, then end an empty one
	task automatic test_line_full();
		send_byte("b");
		send_byte(CH_SPACE);
		repeat (LINE_LIMIT - 3) send_byte(CH_ZERO);
		send_byte("7");
		send_byte(CH_CR);
	endtask

	task automatic test_random_lines();
		int stop_at;
		stop_at = bytes_sent + 270;
		while (bytes_sent < stop_at) send_random_line();
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (12) send_random_line();
		steady = 1'b0;
	endtask

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 17);
	end

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {kind, echo_byte, status, channel, brightness, last};
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d echo=%02h status=%0d channel=%0d bright=%0d last=%0d",
					$time, got.kind, got.echo, got.status, got.channel, got.brightness,
					got.last);
				err_count++;
			end else begin
				want = reply_q.pop_front();
				beats_checked++;
				if (got !== want) begin
					$display("%0t: beat mismatch: expected kind=%0d echo=%02h status=%0d channel=%0d bright=%0d last=%0d",
						$time, want.kind, want.echo, want.status, want.channel,
						want.brightness, want.last);
					$display("%0t:                  actual kind=%0d echo=%02h status=%0d channel=%0d bright=%0d last=%0d",
						$time, got.kind, got.echo, got.status, got.channel,
						got.brightness, got.last);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[rgb_command_line_parser] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rx_byte       = '0;
		out_ready     = 1'b0;
		steady        = 1'b0;
		bytes_sent    = 0;
		beats_checked = 0;
		lines_done    = 0;
		writes_done   = 0;
		err_count     = 0;
		cycles        = 0;
		clear_line();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_missing();
		test_names();
		test_values();
		test_line_full();
		test_random_lines();
		test_back_to_back();

		@(negedge clk);
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d bytes; checked %0d beats over %0d command lines (%0d channel writes).",
			bytes_sent, beats_checked, lines_done, writes_done);
		if (err_count == 0) begin
			$display("[rgb_command_line_parser] OK");
		end else begin
			$display("[rgb_command_line_parser] ERROR");
		end
		$finish;
	end

endmodule
